@@ hdl/i2cra_pkg.sv @@
// Types, constants and sequencer tables of the I2C register access master
`default_nettype none
package i2cra_pkg;

   localparam int WAIT_W = 16;
   localparam int POLL_W = 9;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [POLL_W-1:0] ACK_POLL_LIMIT = POLL_W'(500);

   // register defaults
   localparam logic [WAIT_W-1:0] HALF_PERIOD_RST = WAIT_W'(5);
   localparam logic              ADDR_SHIFT_RST  = 1'b0;
   localparam logic [7:0]        DEV_WR_ADDR_RST = 8'd100;
   localparam logic [7:0]        DEV_RD_ADDR_RST = 8'd101;
   localparam logic [WAIT_W-1:0] GAP_TICKS_RST   = WAIT_W'(1000);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_HALF_PERIOD = 3'd0,
      CSR_ADDR_SHIFT  = 3'd1,
      CSR_DEV_WR_ADDR = 3'd2,
      CSR_DEV_RD_ADDR = 3'd3,
      CSR_GAP_TICKS   = 3'd4
   } csr_index_type;

   // sequencer step numbers; each segment starts at its first step
   localparam logic [4:0] SEG_START  = 5'd0;
   localparam logic [4:0] SEG_WB     = 5'd3;
   localparam logic [4:0] SEG_ACK    = 5'd7;
   localparam logic [4:0] SEG_RB     = 5'd10;
   localparam logic [4:0] SEG_NA     = 5'd16;
   localparam logic [4:0] SEG_STOP   = 5'd19;
   localparam logic [4:0] SEG_GAP    = 5'd22;
   localparam logic [4:0] SEG_DONE   = 5'd23;
   localparam logic [4:0] PH_RB_LAST = 5'd15;
   localparam logic [4:0] PH_IDLE    = 5'd31;

   typedef enum logic [1:0] {
      PIN_LO   = 2'd0,
      PIN_HI   = 2'd1,
      PIN_KEEP = 2'd2,
      PIN_BIT  = 2'd3
   } pin_act_type;

   typedef enum logic [2:0] {
      DUR_ONE     = 3'd0,
      DUR_HALF    = 3'd1,
      DUR_GAP     = 3'd2,
      DUR_POLL_LO = 3'd3,
      DUR_POLL_HI = 3'd4,
      DUR_DONE    = 3'd5
   } dur_type;

   typedef enum logic [1:0] {
      SRC_DEV_WR = 2'd0,
      SRC_REG    = 2'd1,
      SRC_DATA   = 2'd2,
      SRC_DEV_RD = 2'd3
   } src_type;

   typedef struct packed {
      pin_act_type scl;
      pin_act_type en;
      pin_act_type sda;
      dur_type     dur;
      logic        sample;
      logic        loop;
      logic        last;
   } step_type;

   typedef struct packed {
      logic [4:0] seg;
      src_type    src;
   } seg_type;

   localparam int STEP_NUM = 24;
   localparam int SEQ_LEN  = 13;
   localparam logic [3:0] SEQ_LAST = 4'(SEQ_LEN - 1);

   localparam step_type PROG [STEP_NUM] = '{
      '{PIN_KEEP, PIN_HI,   PIN_HI,   DUR_ONE,     1'b0, 1'b0, 1'b0},
      '{PIN_HI,   PIN_KEEP, PIN_KEEP, DUR_HALF,    1'b0, 1'b0, 1'b0},
      '{PIN_KEEP, PIN_KEEP, PIN_LO,   DUR_HALF,    1'b0, 1'b0, 1'b1},
      '{PIN_LO,   PIN_HI,   PIN_KEEP, DUR_HALF,    1'b0, 1'b0, 1'b0},
      '{PIN_HI,   PIN_KEEP, PIN_BIT,  DUR_HALF,    1'b0, 1'b0, 1'b0},
      '{PIN_LO,   PIN_KEEP, PIN_KEEP, DUR_HALF,    1'b0, 1'b1, 1'b0},
      '{PIN_KEEP, PIN_KEEP, PIN_HI,   DUR_HALF,    1'b0, 1'b0, 1'b1},
      '{PIN_HI,   PIN_LO,   PIN_KEEP, DUR_HALF,    1'b0, 1'b0, 1'b0},
      '{PIN_KEEP, PIN_KEEP, PIN_KEEP, DUR_POLL_LO, 1'b0, 1'b0, 1'b0},
      '{PIN_LO,   PIN_KEEP, PIN_KEEP, DUR_HALF,    1'b0, 1'b0, 1'b1},
      '{PIN_KEEP, PIN_KEEP, PIN_HI,   DUR_HALF,    1'b0, 1'b0, 1'b0},
      '{PIN_LO,   PIN_LO,   PIN_KEEP, DUR_HALF,    1'b0, 1'b0, 1'b0},
      '{PIN_HI,   PIN_KEEP, PIN_KEEP, DUR_HALF,    1'b1, 1'b0, 1'b0},
      '{PIN_LO,   PIN_KEEP, PIN_KEEP, DUR_HALF,    1'b0, 1'b1, 1'b0},
      '{PIN_KEEP, PIN_KEEP, PIN_HI,   DUR_HALF,    1'b0, 1'b0, 1'b0},
      '{PIN_LO,   PIN_KEEP, PIN_KEEP, DUR_HALF,    1'b0, 1'b0, 1'b1},
      '{PIN_HI,   PIN_LO,   PIN_KEEP, DUR_HALF,    1'b0, 1'b0, 1'b0},
      '{PIN_KEEP, PIN_KEEP, PIN_KEEP, DUR_POLL_HI, 1'b0, 1'b0, 1'b0},
      '{PIN_LO,   PIN_KEEP, PIN_KEEP, DUR_HALF,    1'b0, 1'b0, 1'b1},
      '{PIN_KEEP, PIN_HI,   PIN_LO,   DUR_ONE,     1'b0, 1'b0, 1'b0},
      '{PIN_HI,   PIN_KEEP, PIN_KEEP, DUR_HALF,    1'b0, 1'b0, 1'b0},
      '{PIN_KEEP, PIN_KEEP, PIN_HI,   DUR_HALF,    1'b0, 1'b0, 1'b1},
      '{PIN_KEEP, PIN_KEEP, PIN_KEEP, DUR_GAP,     1'b0, 1'b0, 1'b1},
      '{PIN_KEEP, PIN_KEEP, PIN_KEEP, DUR_DONE,    1'b0, 1'b0, 1'b1}
   };

   localparam step_type STEP_NONE =
      '{PIN_KEEP, PIN_KEEP, PIN_KEEP, DUR_ONE, 1'b0, 1'b0, 1'b0};

   localparam seg_type SEQ_RD [SEQ_LEN] = '{
      '{SEG_START, SRC_DEV_WR}, '{SEG_WB, SRC_DEV_WR}, '{SEG_ACK, SRC_DEV_WR},
      '{SEG_WB, SRC_REG},       '{SEG_ACK, SRC_DEV_WR}, '{SEG_START, SRC_DEV_WR},
      '{SEG_WB, SRC_DEV_RD},    '{SEG_ACK, SRC_DEV_WR}, '{SEG_RB, SRC_DEV_WR},
      '{SEG_NA, SRC_DEV_WR},    '{SEG_STOP, SRC_DEV_WR}, '{SEG_GAP, SRC_DEV_WR},
      '{SEG_DONE, SRC_DEV_WR}
   };

   localparam seg_type SEQ_WR [SEQ_LEN] = '{
      '{SEG_START, SRC_DEV_WR}, '{SEG_WB, SRC_DEV_WR}, '{SEG_ACK, SRC_DEV_WR},
      '{SEG_WB, SRC_REG},       '{SEG_ACK, SRC_DEV_WR}, '{SEG_WB, SRC_DATA},
      '{SEG_ACK, SRC_DEV_WR},   '{SEG_STOP, SRC_DEV_WR}, '{SEG_GAP, SRC_DEV_WR},
      '{SEG_DONE, SRC_DEV_WR},  '{SEG_DONE, SRC_DEV_WR}, '{SEG_DONE, SRC_DEV_WR},
      '{SEG_DONE, SRC_DEV_WR}
   };

   typedef struct packed {
      logic              req_valid;
      logic              func;
      logic [7:0]        reg_addr;
      logic [7:0]        wr_data;
      logic              sda_in;
   } req_word_type;

   typedef struct packed {
      logic              scl_level;
      logic              sda_enable;
      logic              sda_level;
      logic              busy_res;
      logic              done_res;
      logic [7:0]        rd_data;
   } rsp_word_type;

   typedef struct packed {
      logic [WAIT_W-1:0] half_period;
      logic              addr_shift_mode;
      logic [7:0]        dev_write_addr;
      logic [7:0]        dev_read_addr;
      logic [WAIT_W-1:0] gap_ticks;
   } cfg_type;

   typedef struct packed {
      logic [4:0]        phase;
      logic [WAIT_W-1:0] wait_cnt;
      logic [POLL_W-1:0] poll_cnt;
      logic [3:0]        bit_idx;
      logic [7:0]        shift;
      logic              op;
      logic [7:0]        addr;
      logic [7:0]        data;
      logic [7:0]        rd_byte;
      logic              scl;
      logic              sda_en;
      logic              sda_out;
      logic [3:0]        seq_pos;
   } core_type;

   function automatic step_type step_of(input logic [4:0] phase);
      if (phase < 5'(STEP_NUM)) begin
         return PROG[phase];
      end
      return STEP_NONE;
   endfunction

   function automatic seg_type seq_entry(input logic op, input logic [3:0] pos);
      if (pos <= SEQ_LAST) begin
         return op ? SEQ_WR[pos] : SEQ_RD[pos];
      end
      return SEQ_WR[SEQ_LAST];
   endfunction

endpackage
`default_nettype wire

@@ hdl/i2cra_if.sv @@
// Request, response and register write channel interfaces
`default_nettype none
interface i2cra_req_if;
   logic       valid;
   logic       ready;
   logic       req_valid;
   logic       func;
   logic [7:0] reg_addr;
   logic [7:0] wr_data;
   logic       sda_in;

   modport source (output valid, req_valid, func, reg_addr, wr_data, sda_in, input ready);
   modport sink (input valid, req_valid, func, reg_addr, wr_data, sda_in, output ready);
endinterface

interface i2cra_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_enable;
   logic       sda_level;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rd_data;

   modport source (output valid, scl_level, sda_enable, sda_level, busy_res, done_res,
                   rd_data, input ready);
   modport sink (input valid, scl_level, sda_enable, sda_level, busy_res, done_res,
                 rd_data, output ready);
endinterface

interface i2cra_csr_if;
   logic                                valid;
   logic                                ready;
   logic [i2cra_pkg::CSR_ADDR_W-1:0]    addr;
   logic [i2cra_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

@@ hdl/i2c_register_access_master.sv @@
// I2C master for one register access, advanced one bus tick per request word
// An accepted request word is registered; its response word is registered from it.
// Throughput: one word per clock while half_period is nonzero and rsp_ch is not
//   stalled; the tick sequencer takes up to two steps per clock, so a tick with more
//   zero-length steps (zero half_period or gap_ticks) holds the input until they are done.
// Reset (synchronous): bus idle with SCL high and SDA driven high, read byte zero,
//   registers at their defaults, both channels empty.
`default_nettype none
module i2c_register_access_master (
   input  logic        clock,
   input  logic        reset,
   i2cra_req_if.sink   req_ch,
   i2cra_rsp_if.source rsp_ch,
   i2cra_csr_if.sink   csr_ch
);

   i2cra_pkg::cfg_type      cfg_ff, cfg_in;
   i2cra_pkg::core_type     st_ff, st_in;
   i2cra_pkg::core_type     st_a, st_b, st_fin;
   i2cra_pkg::req_word_type item_ff, item_in;
   logic                    item_vld_ff, item_vld_in;
   i2cra_pkg::rsp_word_type rsp_word_ff, rsp_word_in;
   logic                    rsp_vld_ff, rsp_vld_in;
   logic                    settled;
   logic                    out_free;
   logic                    finish;
   logic                    req_take;
   i2cra_pkg::step_type     fin_step;

   function automatic i2cra_pkg::core_type enter_step(input i2cra_pkg::core_type s,
                                                     input i2cra_pkg::cfg_type c,
                                                     input logic sda);
      i2cra_pkg::step_type p;
      i2cra_pkg::core_type r;
      p = i2cra_pkg::step_of(s.phase);
      r = s;
      case (p.scl)
         i2cra_pkg::PIN_LO: r.scl = 1'b0;
         i2cra_pkg::PIN_HI: r.scl = 1'b1;
         default:           r.scl = s.scl;
      endcase
      case (p.en)
         i2cra_pkg::PIN_LO: r.sda_en = 1'b0;
         i2cra_pkg::PIN_HI: r.sda_en = 1'b1;
         default:           r.sda_en = s.sda_en;
      endcase
      case (p.sda)
         i2cra_pkg::PIN_LO: r.sda_out = 1'b0;
         i2cra_pkg::PIN_HI: r.sda_out = 1'b1;
         i2cra_pkg::PIN_BIT: begin
            r.sda_out = s.shift[7];
            r.shift   = {s.shift[6:0], 1'b0};
         end
         default:           r.sda_out = s.sda_out;
      endcase
      if (p.sample) begin
         r.shift = {r.shift[6:0], sda};
      end
      case (p.dur)
         i2cra_pkg::DUR_HALF: r.wait_cnt = c.half_period;
         i2cra_pkg::DUR_GAP:  r.wait_cnt = c.gap_ticks;
         i2cra_pkg::DUR_POLL_LO, i2cra_pkg::DUR_POLL_HI: begin
            r.poll_cnt = '0;
            r.wait_cnt = '0;
         end
         default:             r.wait_cnt = i2cra_pkg::WAIT_W'(1);
      endcase
      return r;
   endfunction

   function automatic i2cra_pkg::core_type enter_segment(input i2cra_pkg::core_type s,
                                                        input i2cra_pkg::cfg_type c,
                                                        input logic sda);
      i2cra_pkg::seg_type  e;
      i2cra_pkg::core_type r;
      e = i2cra_pkg::seq_entry(s.op, s.seq_pos);
      r = s;
      r.phase   = e.seg;
      r.bit_idx = '0;
      if (e.seg == i2cra_pkg::SEG_RB) begin
         r.shift = '0;
      end else if (e.seg == i2cra_pkg::SEG_WB) begin
         case (e.src)
            i2cra_pkg::SRC_DEV_WR: r.shift = c.dev_write_addr;
            i2cra_pkg::SRC_REG:    r.shift = c.addr_shift_mode ? s.addr : {s.addr[3:0], 4'h0};
            i2cra_pkg::SRC_DATA:   r.shift = s.data;
            default:               r.shift = c.dev_read_addr;
         endcase
      end
      return enter_step(r, c, sda);
   endfunction

   function automatic logic step_done(input i2cra_pkg::core_type s, input logic sda);
      i2cra_pkg::step_type p;
      p = i2cra_pkg::step_of(s.phase);
      case (p.dur)
         i2cra_pkg::DUR_POLL_LO: return !sda || (s.poll_cnt >= i2cra_pkg::ACK_POLL_LIMIT);
         i2cra_pkg::DUR_POLL_HI: return sda || (s.poll_cnt >= i2cra_pkg::ACK_POLL_LIMIT);
         default:                return s.wait_cnt == '0;
      endcase
   endfunction

   function automatic i2cra_pkg::core_type advance(input i2cra_pkg::core_type s,
                                                  input i2cra_pkg::cfg_type c,
                                                  input logic sda);
      i2cra_pkg::step_type p;
      i2cra_pkg::core_type r;
      logic [3:0]          nb;
      p  = i2cra_pkg::step_of(s.phase);
      r  = s;
      nb = s.bit_idx + 4'd1;
      if (p.loop) begin
         r.bit_idx = nb;
         // back to the bit step until eight bits are through
         if (nb < 4'd8) begin
            r.phase = s.phase - 5'd1;
            return enter_step(r, c, sda);
         end
      end
      if (p.last) begin
         if (s.phase == i2cra_pkg::PH_RB_LAST) begin
            r.rd_byte = s.shift;
         end
         if (s.phase == i2cra_pkg::SEG_DONE) begin
            r.phase = i2cra_pkg::PH_IDLE;
            return r;
         end
         if (s.seq_pos <= i2cra_pkg::SEQ_LAST) begin
            r.seq_pos = s.seq_pos + 4'd1;
         end
         return enter_segment(r, c, sda);
      end
      r.phase = s.phase + 5'd1;
      return enter_step(r, c, sda);
   endfunction

   function automatic logic can_move(input i2cra_pkg::core_type s,
                                     input i2cra_pkg::req_word_type it);
      if (s.phase == i2cra_pkg::PH_IDLE) begin
         return it.req_valid;
      end
      return step_done(s, it.sda_in);
   endfunction

   function automatic i2cra_pkg::core_type move(input i2cra_pkg::core_type s,
                                               input i2cra_pkg::cfg_type c,
                                               input i2cra_pkg::req_word_type it);
      i2cra_pkg::core_type r;
      r = s;
      if (s.phase == i2cra_pkg::PH_IDLE) begin
         r.op      = it.func;
         r.addr    = it.reg_addr;
         r.data    = it.wr_data;
         r.seq_pos = '0;
         return enter_segment(r, c, it.sda_in);
      end
      return advance(s, c, it.sda_in);
   endfunction

   // tick sequencer: up to two steps per clock, then the tick's own wait or poll count
   always_comb begin
      st_a     = can_move(st_ff, item_ff) ? move(st_ff, cfg_ff, item_ff) : st_ff;
      st_b     = can_move(st_a, item_ff) ? move(st_a, cfg_ff, item_ff) : st_a;
      settled  = !can_move(st_b, item_ff);
      fin_step = i2cra_pkg::step_of(st_b.phase);
      st_fin   = st_b;
      if (st_b.phase != i2cra_pkg::PH_IDLE) begin
         if (fin_step.dur == i2cra_pkg::DUR_POLL_LO || fin_step.dur == i2cra_pkg::DUR_POLL_HI) begin
            st_fin.poll_cnt = st_b.poll_cnt + i2cra_pkg::POLL_W'(1);
         end else if (st_b.wait_cnt != '0) begin
            st_fin.wait_cnt = st_b.wait_cnt - i2cra_pkg::WAIT_W'(1);
         end
      end
   end

   always_comb begin
      out_free    = !rsp_vld_ff || rsp_ch.ready;
      finish      = item_vld_ff && settled && out_free;
      req_take    = req_ch.valid && req_ch.ready;

      st_in = st_ff;
      if (item_vld_ff && !settled) begin
         st_in = st_b;
      end else if (finish) begin
         st_in = st_fin;
      end

      item_in.req_valid = req_ch.req_valid;
      item_in.func      = req_ch.func;
      item_in.reg_addr  = req_ch.reg_addr;
      item_in.wr_data   = req_ch.wr_data;
      item_in.sda_in    = req_ch.sda_in;
      if (!req_take) begin
         item_in = item_ff;
      end
      item_vld_in = req_take ? 1'b1 : (finish ? 1'b0 : item_vld_ff);

      rsp_word_in = rsp_word_ff;
      if (finish) begin
         rsp_word_in.scl_level  = st_fin.scl;
         rsp_word_in.sda_enable = st_fin.sda_en;
         rsp_word_in.sda_level  = st_fin.sda_out;
         rsp_word_in.busy_res   = st_fin.phase != i2cra_pkg::PH_IDLE;
         rsp_word_in.done_res   = (st_fin.phase != i2cra_pkg::PH_IDLE) &&
                                  (fin_step.dur == i2cra_pkg::DUR_DONE);
         rsp_word_in.rd_data    = st_fin.rd_byte;
      end
      rsp_vld_in = finish ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_vld_ff);

      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.addr)
            i2cra_pkg::CSR_HALF_PERIOD: cfg_in.half_period     = csr_ch.data;
            i2cra_pkg::CSR_ADDR_SHIFT:  cfg_in.addr_shift_mode = csr_ch.data[0];
            i2cra_pkg::CSR_DEV_WR_ADDR: cfg_in.dev_write_addr  = csr_ch.data[7:0];
            i2cra_pkg::CSR_DEV_RD_ADDR: cfg_in.dev_read_addr   = csr_ch.data[7:0];
            i2cra_pkg::CSR_GAP_TICKS:   cfg_in.gap_ticks       = csr_ch.data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period     <= i2cra_pkg::HALF_PERIOD_RST;
         cfg_ff.addr_shift_mode <= i2cra_pkg::ADDR_SHIFT_RST;
         cfg_ff.dev_write_addr  <= i2cra_pkg::DEV_WR_ADDR_RST;
         cfg_ff.dev_read_addr   <= i2cra_pkg::DEV_RD_ADDR_RST;
         cfg_ff.gap_ticks       <= i2cra_pkg::GAP_TICKS_RST;
         st_ff                  <= '0;
         st_ff.phase            <= i2cra_pkg::PH_IDLE;
         st_ff.scl              <= 1'b1;
         st_ff.sda_en           <= 1'b1;
         st_ff.sda_out          <= 1'b1;
         item_vld_ff            <= 1'b0;
         rsp_vld_ff             <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         st_ff       <= st_in;
         item_vld_ff <= item_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_ch.ready      = !item_vld_ff || finish;
   assign csr_ch.ready      = 1'b1;
   assign rsp_ch.valid      = rsp_vld_ff;
   assign rsp_ch.scl_level  = rsp_word_ff.scl_level;
   assign rsp_ch.sda_enable = rsp_word_ff.sda_enable;
   assign rsp_ch.sda_level  = rsp_word_ff.sda_level;
   assign rsp_ch.busy_res   = rsp_word_ff.busy_res;
   assign rsp_ch.done_res   = rsp_word_ff.done_res;
   assign rsp_ch.rd_data    = rsp_word_ff.rd_data;

endmodule
`default_nettype wire

@@ hdl/i2cra_checker.sv @@
// Port checks of the I2C register access master and their bind
`default_nettype none
module i2cra_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_scl,
   input logic       rsp_sda_en,
   input logic       rsp_sda,
   input logic       rsp_busy,
   input logic       rsp_done,
   input logic [7:0] rsp_rd_data
);

   logic       req_acc;
   logic       rsp_acc;
   logic [1:0] cnt_ff, cnt_in;
   logic       last_done_ff, last_done_in;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (req_acc && !rsp_acc) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (rsp_acc && !req_acc) begin
         cnt_in = cnt_ff - 2'd1;
      end
      last_done_in = rsp_acc ? rsp_done : last_done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         last_done_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         last_done_ff <= last_done_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_scl) && $stable(rsp_sda_en) &&
         $stable(rsp_sda) && $stable(rsp_busy) && $stable(rsp_done) && $stable(rsp_rd_data))
      else $error("response word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> cnt_ff != 2'd0)
      else $error("response word without a request word");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("more than two words in flight");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && rsp_done |-> rsp_busy && !last_done_ff)
      else $error("done not a single busy tick");

endmodule

bind i2c_register_access_master i2cra_checker u_i2cra_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_scl     (rsp_ch.scl_level),
   .rsp_sda_en  (rsp_ch.sda_enable),
   .rsp_sda     (rsp_ch.sda_level),
   .rsp_busy    (rsp_ch.busy_res),
   .rsp_done    (rsp_ch.done_res),
   .rsp_rd_data (rsp_ch.rd_data)
);
`default_nettype wire

@@ tb/i2cra_checker.sv @@
// Checker for the I2C register access master: predicts every response word and compares it
`timescale 1ns / 100ps
module i2cra_bus_checker
   import i2cra_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   i2cra_req_if  req_mon,
   i2cra_rsp_if  rsp_mon,
   i2cra_csr_if  csr_mon,
   output int    mismatches,
   output int    words_checked
);

   // bus program: pin actions and duration of every sequencer step
   localparam step_type BUS_STEPS [24] = '{
      '{PIN_KEEP, PIN_HI,   PIN_HI,   DUR_ONE,     1'b0, 1'b0, 1'b0},
      '{PIN_HI,   PIN_KEEP, PIN_KEEP, DUR_HALF,    1'b0, 1'b0, 1'b0},
      '{PIN_KEEP, PIN_KEEP, PIN_LO,   DUR_HALF,    1'b0, 1'b0, 1'b1},
      '{PIN_LO,   PIN_HI,   PIN_KEEP, DUR_HALF,    1'b0, 1'b0, 1'b0},
      '{PIN_HI,   PIN_KEEP, PIN_BIT,  DUR_HALF,    1'b0, 1'b0, 1'b0},
      '{PIN_LO,   PIN_KEEP, PIN_KEEP, DUR_HALF,    1'b0, 1'b1, 1'b0},
      '{PIN_KEEP, PIN_KEEP, PIN_HI,   DUR_HALF,    1'b0, 1'b0, 1'b1},
      '{PIN_HI,   PIN_LO,   PIN_KEEP, DUR_HALF,    1'b0, 1'b0, 1'b0},
      '{PIN_KEEP, PIN_KEEP, PIN_KEEP, DUR_POLL_LO, 1'b0, 1'b0, 1'b0},
      '{PIN_LO,   PIN_KEEP, PIN_KEEP, DUR_HALF,    1'b0, 1'b0, 1'b1},
      '{PIN_KEEP, PIN_KEEP, PIN_HI,   DUR_HALF,    1'b0, 1'b0, 1'b0},
      '{PIN_LO,   PIN_LO,   PIN_KEEP, DUR_HALF,    1'b0, 1'b0, 1'b0},
      '{PIN_HI,   PIN_KEEP, PIN_KEEP, DUR_HALF,    1'b1, 1'b0, 1'b0},
      '{PIN_LO,   PIN_KEEP, PIN_KEEP, DUR_HALF,    1'b0, 1'b1, 1'b0},
      '{PIN_KEEP, PIN_KEEP, PIN_HI,   DUR_HALF,    1'b0, 1'b0, 1'b0},
      '{PIN_LO,   PIN_KEEP, PIN_KEEP, DUR_HALF,    1'b0, 1'b0, 1'b1},
      '{PIN_HI,   PIN_LO,   PIN_KEEP, DUR_HALF,    1'b0, 1'b0, 1'b0},
      '{PIN_KEEP, PIN_KEEP, PIN_KEEP, DUR_POLL_HI, 1'b0, 1'b0, 1'b0},
      '{PIN_LO,   PIN_KEEP, PIN_KEEP, DUR_HALF,    1'b0, 1'b0, 1'b1},
      '{PIN_KEEP, PIN_HI,   PIN_LO,   DUR_ONE,     1'b0, 1'b0, 1'b0},
      '{PIN_HI,   PIN_KEEP, PIN_KEEP, DUR_HALF,    1'b0, 1'b0, 1'b0},
      '{PIN_KEEP, PIN_KEEP, PIN_HI,   DUR_HALF,    1'b0, 1'b0, 1'b1},
      '{PIN_KEEP, PIN_KEEP, PIN_KEEP, DUR_GAP,     1'b0, 1'b0, 1'b1},
      '{PIN_KEEP, PIN_KEEP, PIN_KEEP, DUR_DONE,    1'b0, 1'b0, 1'b1}
   };

   localparam seg_type READ_SEGS [SEQ_LEN] = '{
      '{SEG_START, SRC_DEV_WR}, '{SEG_WB, SRC_DEV_WR}, '{SEG_ACK, SRC_DEV_WR},
      '{SEG_WB, SRC_REG},       '{SEG_ACK, SRC_DEV_WR}, '{SEG_START, SRC_DEV_WR},
      '{SEG_WB, SRC_DEV_RD},    '{SEG_ACK, SRC_DEV_WR}, '{SEG_RB, SRC_DEV_WR},
      '{SEG_NA, SRC_DEV_WR},    '{SEG_STOP, SRC_DEV_WR}, '{SEG_GAP, SRC_DEV_WR},
      '{SEG_DONE, SRC_DEV_WR}
   };

   localparam seg_type WRITE_SEGS [SEQ_LEN] = '{
      '{SEG_START, SRC_DEV_WR}, '{SEG_WB, SRC_DEV_WR}, '{SEG_ACK, SRC_DEV_WR},
      '{SEG_WB, SRC_REG},       '{SEG_ACK, SRC_DEV_WR}, '{SEG_WB, SRC_DATA},
      '{SEG_ACK, SRC_DEV_WR},   '{SEG_STOP, SRC_DEV_WR}, '{SEG_GAP, SRC_DEV_WR},
      '{SEG_DONE, SRC_DEV_WR},  '{SEG_DONE, SRC_DEV_WR}, '{SEG_DONE, SRC_DEV_WR},
      '{SEG_DONE, SRC_DEV_WR}
   };

   cfg_type           regs;
   logic [4:0]        phase;
   logic [WAIT_W-1:0] wait_cnt;
   logic [POLL_W-1:0] poll_cnt;
   logic [3:0]        bit_idx;
   logic [7:0]        shifter;
   logic              is_write;
   logic [7:0]        addr_q;
   logic [7:0]        data_q;
   logic [7:0]        rd_byte;
   logic              scl_q;
   logic              en_q;
   logic              sda_q;
   logic [3:0]        seg_pos;

   rsp_word_type      bus_expect_q[$];
   int                mismatch_total;

   assign mismatches = mismatch_total;

   function automatic void load_step(input logic sda);
      step_type s;
      s = BUS_STEPS[phase];
      if (s.scl != PIN_KEEP) scl_q = (s.scl == PIN_HI);
      if (s.en != PIN_KEEP) en_q = (s.en == PIN_HI);
      if (s.sda == PIN_BIT) begin
         sda_q = shifter[7];
         shifter = {shifter[6:0], 1'b0};
      end else if (s.sda != PIN_KEEP) begin
         sda_q = (s.sda == PIN_HI);
      end
      if (s.sample) shifter = {shifter[6:0], sda};
      case (s.dur)
         DUR_HALF: wait_cnt = regs.half_period;
         DUR_GAP: wait_cnt = regs.gap_ticks;
         DUR_POLL_LO, DUR_POLL_HI: begin
            poll_cnt = '0;
            wait_cnt = '0;
         end
         default: wait_cnt = WAIT_W'(1);
      endcase
   endfunction

   function automatic void begin_segment(input logic sda);
      seg_type e;
      if (seg_pos < SEQ_LEN) begin
         e = is_write ? WRITE_SEGS[seg_pos] : READ_SEGS[seg_pos];
      end else begin
         e = WRITE_SEGS[SEQ_LEN-1];
      end
      phase = e.seg;
      bit_idx = '0;
      if (e.seg == SEG_RB) begin
         shifter = '0;
      end else if (e.seg == SEG_WB) begin
         case (e.src)
            SRC_DEV_WR: shifter = regs.dev_write_addr;
            SRC_REG: shifter = regs.addr_shift_mode ? addr_q : {addr_q[3:0], 4'h0};
            SRC_DATA: shifter = data_q;
            default: shifter = regs.dev_read_addr;
         endcase
      end
      load_step(sda);
   endfunction

   function automatic logic step_over(input logic sda);
      case (BUS_STEPS[phase].dur)
         DUR_POLL_LO: return !sda || poll_cnt >= ACK_POLL_LIMIT;
         DUR_POLL_HI: return sda || poll_cnt >= ACK_POLL_LIMIT;
         default: return wait_cnt == '0;
      endcase
   endfunction

   function automatic void next_step(input logic sda);
      step_type s;
      s = BUS_STEPS[phase];
      if (s.loop) begin
         bit_idx = bit_idx + 4'd1;
         if (bit_idx < 4'd8) begin
            phase = phase - 5'd1;
            load_step(sda);
            return;
         end
      end
      if (s.last) begin
         if (phase == PH_RB_LAST) rd_byte = shifter;
         if (phase == SEG_DONE) begin
            phase = PH_IDLE;
            return;
         end
         if (seg_pos < SEQ_LEN) seg_pos = seg_pos + 4'd1;
         begin_segment(sda);
         return;
      end
      phase = phase + 5'd1;
      load_step(sda);
   endfunction

   // finish every step whose time is used up, zero-length ones included
   function automatic void settle_bus(input logic sda);
      while (phase != PH_IDLE && step_over(sda)) next_step(sda);
   endfunction

   function automatic rsp_word_type bus_tick(input req_word_type w);
      rsp_word_type r;
      r = '0;
      if (phase != PH_IDLE) settle_bus(w.sda_in);
      if (phase == PH_IDLE && w.req_valid) begin
         is_write = w.func;
         addr_q = w.reg_addr;
         data_q = w.wr_data;
         seg_pos = '0;
         begin_segment(w.sda_in);
         settle_bus(w.sda_in);
      end
      if (phase != PH_IDLE) begin
         r.busy_res = 1'b1;
         case (BUS_STEPS[phase].dur)
            DUR_DONE: begin
               r.done_res = 1'b1;
               if (wait_cnt != '0) wait_cnt = wait_cnt - 1'b1;
            end
            DUR_POLL_LO, DUR_POLL_HI: poll_cnt = poll_cnt + 1'b1;
            default: if (wait_cnt != '0) wait_cnt = wait_cnt - 1'b1;
         endcase
      end
      r.scl_level = scl_q;
      r.sda_enable = en_q;
      r.sda_level = sda_q;
      r.rd_data = rd_byte;
      return r;
   endfunction

   function automatic void check_field(input string field, input logic [7:0] exp_v,
                                       input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         mismatch_total++;
         if (mismatch_total <= 100)
            $error("%s: expected %0h, got %0h", field, exp_v, act_v);
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type exp_w;
      req_word_type in_w;
      if (reset) begin
         regs.half_period <= HALF_PERIOD_RST;
         regs.addr_shift_mode <= ADDR_SHIFT_RST;
         regs.dev_write_addr <= DEV_WR_ADDR_RST;
         regs.dev_read_addr <= DEV_RD_ADDR_RST;
         regs.gap_ticks <= GAP_TICKS_RST;
         phase = PH_IDLE;
         wait_cnt = '0;
         poll_cnt = '0;
         bit_idx = '0;
         shifter = '0;
         is_write = 1'b0;
         addr_q = '0;
         data_q = '0;
         rd_byte = '0;
         scl_q = 1'b1;
         en_q = 1'b1;
         sda_q = 1'b1;
         seg_pos = '0;
         bus_expect_q.delete();
         mismatch_total = 0;
         words_checked <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.addr)
               CSR_HALF_PERIOD: regs.half_period <= csr_mon.data;
               CSR_ADDR_SHIFT: regs.addr_shift_mode <= csr_mon.data[0];
               CSR_DEV_WR_ADDR: regs.dev_write_addr <= csr_mon.data[7:0];
               CSR_DEV_RD_ADDR: regs.dev_read_addr <= csr_mon.data[7:0];
               CSR_GAP_TICKS: regs.gap_ticks <= csr_mon.data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            in_w.req_valid = req_mon.req_valid;
            in_w.func = req_mon.func;
            in_w.reg_addr = req_mon.reg_addr;
            in_w.wr_data = req_mon.wr_data;
            in_w.sda_in = req_mon.sda_in;
            bus_expect_q.push_back(bus_tick(in_w));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            words_checked <= words_checked + 1;
            if (bus_expect_q.size() == 0) begin
               mismatch_total++;
               $error("response word with no request word outstanding");
            end else begin
               exp_w = bus_expect_q.pop_front();
               check_field("scl_level", exp_w.scl_level, rsp_mon.scl_level);
               check_field("sda_enable", exp_w.sda_enable, rsp_mon.sda_enable);
               check_field("sda_level", exp_w.sda_level, rsp_mon.sda_level);
               check_field("busy_res", exp_w.busy_res, rsp_mon.busy_res);
               check_field("done_res", exp_w.done_res, rsp_mon.done_res);
               check_field("rd_data", exp_w.rd_data, rsp_mon.rd_data);
            end
         end
      end
   end

endmodule

@@ tb/tb.sv @@
// Top of the I2C register access master testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb;
   import i2cra_pkg::*;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;
   localparam int   CYCLE_LIMIT = 600000;

   logic clock;
   logic reset;
   int   mismatches;
   int   words_checked;
   int   ticks_sent;
   int   cycle_count;
   int   sender_idle_pct;
   int   recv_stall_pct;
   int   sda_run_left;
   logic sda_run_val;

   i2cra_req_if req_ch ();
   i2cra_rsp_if rsp_ch ();
   i2cra_csr_if csr_ch ();

   i2c_register_access_master dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   i2cra_bus_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_mon       (csr_ch),
      .mismatches    (mismatches),
      .words_checked (words_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic req_word_type mk_tick(input logic req, input logic func,
                                            input logic [7:0] addr, input logic [7:0] data,
                                            input logic sda);
      req_word_type w;
      w.req_valid = req;
      w.func = func;
      w.reg_addr = addr;
      w.wr_data = data;
      w.sda_in = sda;
      return w;
   endfunction

   // caller lowers valid after its last word
   task automatic send_tick(input req_word_type w);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.req_valid <= w.req_valid;
      req_ch.func <= w.func;
      req_ch.reg_addr <= w.reg_addr;
      req_ch.wr_data <= w.wr_data;
      req_ch.sda_in <= w.sda_in;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      ticks_sent++;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.addr <= idx;
      csr_ch.data <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   task automatic write_regs(input logic [15:0] half, input logic shift, input logic [7:0] wr,
                             input logic [7:0] rd, input logic [15:0] gap);
      write_reg(CSR_HALF_PERIOD, half);
      write_reg(CSR_ADDR_SHIFT, {15'd0, shift});
      write_reg(CSR_DEV_WR_ADDR, {8'd0, wr});
      write_reg(CSR_DEV_RD_ADDR, {8'd0, rd});
      write_reg(CSR_GAP_TICKS, gap);
      csr_ch.valid <= 1'b0;
   endtask

   // all words answered, plus a few clocks for the two-stage pipe
   task automatic drain;
      while (words_checked != ticks_sent) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // SDA mostly toggles in short runs; now and then it is held long enough
   // to run an ack poll out to its limit
   task automatic run_random(input int count);
      req_word_type w;
      for (int n = 0; n < count; n++) begin
         if (sda_run_left == 0) begin
            sda_run_val = $urandom_range(1);
            sda_run_left = ($urandom_range(29) == 0) ? $urandom_range(530, 505)
                                                     : $urandom_range(6, 1);
         end
         sda_run_left--;
         w.req_valid = ($urandom_range(2) == 0);
         w.func = $urandom_range(1);
         w.reg_addr = $urandom_range(255);
         w.wr_data = $urandom_range(255);
         w.sda_in = sda_run_val;
         send_tick(w);
      end
      req_ch.valid <= 1'b0;
   endtask

   // back-to-back accesses of one kind with SDA held
   task automatic run_held(input int count, input logic func, input logic sda);
      for (int n = 0; n < count; n++)
         send_tick(mk_tick(1'b1, func, 8'($urandom_range(255)), 8'($urandom_range(255)), sda));
      req_ch.valid <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      sender_idle_pct = 0;
      recv_stall_pct = 0;
      ticks_sent = 0;
      cycle_count = 0;
      sda_run_left = 0;
      sda_run_val = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.req_valid = 1'b0;
      req_ch.func = OP_READ;
      req_ch.reg_addr = 8'h00;
      req_ch.wr_data = 8'h00;
      req_ch.sda_in = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.addr = CSR_HALF_PERIOD;
      csr_ch.data = 16'h0000;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset defaults, field extremes, requests while busy
      send_tick(mk_tick(1'b0, OP_READ, 8'h00, 8'h00, 1'b0));
      send_tick(mk_tick(1'b0, OP_WRITE, 8'hff, 8'hff, 1'b1));
      send_tick(mk_tick(1'b1, OP_WRITE, 8'hff, 8'hff, 1'b0));
      send_tick(mk_tick(1'b1, OP_READ, 8'h00, 8'h00, 1'b1));
      send_tick(mk_tick(1'b1, OP_WRITE, 8'h5a, 8'ha5, 1'b0));
      send_tick(mk_tick(1'b1, OP_READ, 8'ha5, 8'h5a, 1'b1));
      for (int n = 0; n < 14; n++)
         send_tick(mk_tick(1'b0, OP_READ, 8'h00, 8'h00, n[0]));
      req_ch.valid <= 1'b0;
      drain();

      write_regs(16'd1, 1'b1, 8'ha0, 8'ha1, 16'd0);
      run_random(400);
      drain();

      // zero half period and gap: zero-length waits in every half and gap step
      write_regs(16'd0, 1'b0, 8'h00, 8'hff, 16'd0);
      sender_idle_pct = 55;
      run_random(300);
      drain();

      write_regs(16'd2, 1'b1, 8'hff, 8'h00, 16'd3);
      sender_idle_pct = 0;
      recv_stall_pct = 55;
      run_random(400);
      drain();

      write_regs(16'd1, 1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)), 16'd1);
      sender_idle_pct = 37;
      recv_stall_pct = 37;
      run_random(500);
      drain();

      write_regs(16'd3, 1'($urandom_range(1)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 16'd2);
      sender_idle_pct = 0;
      recv_stall_pct = 0;
      run_random(350);
      drain();

      // reads with SDA low: acks come at once, the no-ack poll runs out
      write_regs(16'd1, 1'b1, 8'h3c, 8'h3d, 16'd0);
      sender_idle_pct = 37;
      recv_stall_pct = 37;
      run_held(800, OP_READ, 1'b0);
      drain();

      // writes with SDA high: every ack poll runs out
      write_regs(16'd1, 1'b0, 8'hc3, 8'hc2, 16'd0);
      sender_idle_pct = 55;
      recv_stall_pct = 0;
      run_held(700, OP_WRITE, 1'b1);
      drain();

      write_regs(16'hffff, 1'b1, 8'hff, 8'hff, 16'hffff);
      sender_idle_pct = 0;
      recv_stall_pct = 55;
      run_random(100);
      drain();

      repeat (10) @(posedge clock);
      if (mismatches == 0 && words_checked == ticks_sent) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/i2cra_pkg.sv
hdl/i2cra_if.sv
hdl/i2c_register_access_master.sv
hdl/i2cra_checker.sv
tb/i2cra_checker.sv
tb/tb.sv
